// ===== design/websocket_frame_receiver_assert.svh =====
// ---------------------------------------------------------------------------
// websocket_frame_receiver_assert.svh
// assertion macros for the frame receiver checker
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define WFR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// consequent must hold in the cycle after the antecedent
`define WFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

// ===== design/wfr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfr_pkg
// shared types and constants for the websocket frame receiver
// ---------------------------------------------------------------------------
package wfr_pkg;

    // result kinds
    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_PING_BYTE = 3'd1;
    localparam logic [2:0] KIND_PING_NULL = 3'd2;
    localparam logic [2:0] KIND_CLOSE     = 3'd3;
    localparam logic [2:0] KIND_KEEPALIVE = 3'd4;

    // frame opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // close status codes
    localparam logic [15:0] CC_NORMAL    = 16'd1000;
    localparam logic [15:0] CC_PROTOCOL  = 16'd1002;
    localparam logic [15:0] CC_TYPE      = 16'd1003;
    localparam logic [15:0] CC_OVERLARGE = 16'd1009;

    // length limits
    localparam logic [15:0] CONTROL_MAX = 16'd125;
    localparam logic [6:0]  LEN7_EXT16  = 7'd126;
    localparam logic [6:0]  LEN7_EXT64  = 7'd127;

    // configuration register indexes
    localparam logic [1:0] REG_MASK_REQ    = 2'd0;
    localparam logic [1:0] REG_DATA_TYPE   = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    // configuration register contents
    typedef struct packed {
        logic        mask_req;
        logic [1:0]  data_type;
        logic [15:0] max_payload;
    } cfg_t;

    // one queued result: raw byte plus its mask lane, unmasked at the back
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  raw;
        logic [7:0]  mask;
        logic        last;
        logic        fin;
        logic [15:0] code;
    } entry_t;

endpackage

// ===== design/wfr_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfr_front
// header parser: takes one byte or tick per transfer and classifies it
// ---------------------------------------------------------------------------
module wfr_front import wfr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_fire,
    input  logic       cmd,
    input  logic [7:0] in_byte,
    output logic       push,
    output entry_t     push_entry
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_LENHI   = 3'd2;
    localparam logic [2:0] PH_LENLO   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CLOSED  = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        fin_reg, fin_next;
    logic        masked_reg, masked_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] bcnt_reg, bcnt_next;
    logic [31:0] mkey_reg, mkey_next;
    logic [15:0] pcc_reg, pcc_next;

    logic [6:0]  len7;
    logic [15:0] ld_len;
    logic        ld_masked;
    logic        ld_ctrl_bad;
    logic        ld_big;
    logic [15:0] hd_len;
    logic        hd_type_bad;
    logic        hd_op_bad;
    logic [16:0] pl_sum;
    logic        pl_last;
    logic [7:0]  pl_mask;
    logic [7:0]  pl_byte;
    logic [15:0] pl_pcc;

    // length and opcode checks, shared by the header steps
    always_comb
    begin
        len7        = in_byte[6:0];
        ld_len      = (phase_reg == PH_HDR1) ? {9'd0, len7} : {plen_reg[15:8], in_byte};
        ld_masked   = (phase_reg == PH_HDR1) ? in_byte[7] : masked_reg;
        ld_ctrl_bad = opcode_reg[3] && (!fin_reg || (ld_len > CONTROL_MAX));
        ld_big      = ld_len > cfg.max_payload;
        hd_len      = (phase_reg == PH_KEY) ? plen_reg : ld_len;
        hd_type_bad = ((opcode_reg == OP_TEXT) || (opcode_reg == OP_BINARY))
                      && (opcode_reg != {2'b00, cfg.data_type});
        hd_op_bad   = !(opcode_reg inside {OP_CONT, OP_TEXT, OP_BINARY,
                                           OP_CLOSE, OP_PING, OP_PONG});
    end

    // payload byte position, mask lane and unmasked value
    always_comb
    begin
        pl_sum  = {1'b0, bcnt_reg} + 17'd1;
        pl_last = pl_sum >= {1'b0, plen_reg};
        case (bcnt_reg[1:0])
            2'd0:    pl_mask = mkey_reg[31:24];
            2'd1:    pl_mask = mkey_reg[23:16];
            2'd2:    pl_mask = mkey_reg[15:8];
            default: pl_mask = mkey_reg[7:0];
        endcase
        if (!masked_reg)
        begin
            pl_mask = 8'h00;
        end
        pl_byte = in_byte ^ pl_mask;
        pl_pcc  = (bcnt_reg < 16'd2) ? {pcc_reg[7:0], pl_byte} : pcc_reg;
    end

    // frame state machine
    always_comb
    begin : fsm
        logic        run_ld;
        logic        run_hd;
        logic        do_close;
        logic [15:0] cc;

        run_ld      = 1'b0;
        run_hd      = 1'b0;
        do_close    = 1'b0;
        cc          = CC_NORMAL;
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        plen_next   = plen_reg;
        bcnt_next   = bcnt_reg;
        mkey_next   = mkey_reg;
        pcc_next    = pcc_reg;
        push        = 1'b0;
        push_entry  = '0;

        if (in_fire && (phase_reg != PH_CLOSED))
        begin
            if (cmd)
            begin
                // read timeout tick asks for a keepalive only between frames
                if (phase_reg == PH_IDLE)
                begin
                    push            = 1'b1;
                    push_entry.kind = KIND_KEEPALIVE;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        fin_next    = in_byte[7];
                        opcode_next = in_byte[3:0];
                        phase_next  = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        masked_next = in_byte[7];
                        if (in_byte[7] != cfg.mask_req)
                        begin
                            do_close = 1'b1;
                            cc       = CC_PROTOCOL;
                        end
                        else if (len7 == LEN7_EXT64)
                        begin
                            do_close = 1'b1;
                            cc       = CC_OVERLARGE;
                        end
                        else if (len7 == LEN7_EXT16)
                        begin
                            plen_next  = '0;
                            phase_next = PH_LENHI;
                        end
                        else
                        begin
                            plen_next = ld_len;
                            run_ld    = 1'b1;
                        end
                    end
                    PH_LENHI:
                    begin
                        plen_next  = {in_byte, 8'h00};
                        phase_next = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        plen_next = ld_len;
                        if (ld_len < {9'd0, LEN7_EXT16})
                        begin
                            do_close = 1'b1;
                            cc       = CC_PROTOCOL;
                        end
                        else
                        begin
                            run_ld = 1'b1;
                        end
                    end
                    PH_KEY:
                    begin
                        mkey_next = {mkey_reg[23:0], in_byte};
                        bcnt_next = bcnt_reg + 16'd1;
                        if (bcnt_reg == 16'd3)
                        begin
                            run_hd = 1'b1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        bcnt_next = pl_sum[15:0];
                        if (pl_last)
                        begin
                            phase_next = PH_IDLE;
                        end
                        case (opcode_reg)
                            OP_CONT, OP_TEXT, OP_BINARY, OP_PING:
                            begin
                                push            = 1'b1;
                                push_entry.kind = (opcode_reg == OP_PING) ?
                                                  KIND_PING_BYTE : KIND_DATA;
                                push_entry.raw  = in_byte;
                                push_entry.mask = pl_mask;
                                push_entry.last = pl_last;
                                push_entry.fin  = fin_reg;
                            end
                            OP_CLOSE:
                            begin
                                pcc_next = pl_pcc;
                                if (pl_last)
                                begin
                                    do_close = 1'b1;
                                    cc       = (plen_reg >= 16'd2) ? pl_pcc : CC_NORMAL;
                                end
                            end
                            default:
                            begin
                                push = 1'b0;
                            end
                        endcase
                    end
                    default:
                    begin
                        phase_next = PH_CLOSED;
                    end
                endcase

                // end of the length field: control frame and size checks
                if (run_ld)
                begin
                    if (ld_ctrl_bad)
                    begin
                        do_close = 1'b1;
                        cc       = CC_PROTOCOL;
                    end
                    else if (ld_big)
                    begin
                        do_close = 1'b1;
                        cc       = CC_OVERLARGE;
                    end
                    else if (ld_masked)
                    begin
                        bcnt_next  = '0;
                        mkey_next  = '0;
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        run_hd = 1'b1;
                    end
                end

                // end of the header: opcode checks and empty frames
                if (run_hd)
                begin
                    bcnt_next = '0;
                    pcc_next  = '0;
                    if (hd_type_bad)
                    begin
                        do_close = 1'b1;
                        cc       = CC_TYPE;
                    end
                    else if (hd_op_bad)
                    begin
                        do_close = 1'b1;
                        cc       = CC_PROTOCOL;
                    end
                    else if (hd_len == 16'd0)
                    begin
                        phase_next = PH_IDLE;
                        if (opcode_reg == OP_CLOSE)
                        begin
                            do_close = 1'b1;
                            cc       = CC_NORMAL;
                        end
                        else if (opcode_reg == OP_PING)
                        begin
                            push            = 1'b1;
                            push_entry.kind = KIND_PING_NULL;
                            push_entry.fin  = fin_reg;
                        end
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end

            // any close ends the session until reset
            if (do_close)
            begin
                phase_next      = PH_CLOSED;
                push            = 1'b1;
                push_entry      = '0;
                push_entry.kind = KIND_CLOSE;
                push_entry.code = cc;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            plen_reg   <= '0;
            bcnt_reg   <= '0;
            mkey_reg   <= '0;
            pcc_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            plen_reg   <= plen_next;
            bcnt_reg   <= bcnt_next;
            mkey_reg   <= mkey_next;
            pcc_reg    <= pcc_next;
        end
    end

endmodule

// ===== design/wfr_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfr_queue
// two-entry result queue between the parser and the output stage
// ---------------------------------------------------------------------------
module wfr_queue import wfr_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   nonempty,
    output entry_t head
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign nonempty = count_reg != 2'd0;
    assign head     = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/wfr_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfr_back
// output stage: unmasks queued bytes and holds the result for transfer
// ---------------------------------------------------------------------------
module wfr_back import wfr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_nonempty,
    input  entry_t      q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        final_fragment,
    output logic [15:0] close_code
);

    logic        valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg;
    logic        fin_reg;
    logic [15:0] code_reg;

    // take the head whenever the output register is free or being emptied
    assign q_pop = q_nonempty && (!valid_reg || out_ready);

    // unmask payload bytes; other kinds carry no byte
    always_comb
    begin
        if ((q_head.kind == KIND_DATA) || (q_head.kind == KIND_PING_BYTE))
        begin
            byte_next = q_head.raw ^ q_head.mask;
        end
        else
        begin
            byte_next = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg <= q_head.kind;
            byte_reg <= byte_next;
            last_reg <= q_head.last;
            fin_reg  <= q_head.fin;
            code_reg <= q_head.code;
        end
    end

    assign out_valid      = valid_reg;
    assign kind           = kind_reg;
    assign out_byte       = byte_reg;
    assign last           = last_reg;
    assign final_fragment = fin_reg;
    assign close_code     = code_reg;

endmodule

// ===== design/websocket_frame_receiver.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// websocket_frame_receiver
// byte-serial websocket frame receiver with payload unmasking
// ---------------------------------------------------------------------------
// Takes one stream byte or read-timeout tick per transfer and sustains one
// transfer per cycle: the header parser finishes each item in the cycle it
// is accepted and writes any result into a two-entry queue, and a registered
// output stage takes it from the queue, unmasks it and presents it. in_ready
// drops only while the queue is full, i.e. when the output side has stalled.
// After any close result the receiver ignores all input until reset.
// Configuration writes are taken at once (cfg_ready is always high) and must
// only occur while the block is idle.
module websocket_frame_receiver import wfr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        final_fragment,
    output logic [15:0] close_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t   cfg_reg;
    logic   in_fire;
    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   q_nonempty;
    logic   q_pop;
    entry_t q_head;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign in_fire   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mask_req    <= 1'b1;
            cfg_reg.data_type   <= 2'd1;
            cfg_reg.max_payload <= 16'hFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MASK_REQ:    cfg_reg.mask_req    <= cfg_data[0];
                REG_DATA_TYPE:   cfg_reg.data_type   <= cfg_data[1:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    wfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_fire    (in_fire),
        .cmd        (cmd),
        .in_byte    (in_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    wfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .nonempty   (q_nonempty),
        .head       (q_head)
    );

    wfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_nonempty     (q_nonempty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .out_byte       (out_byte),
        .last           (last),
        .final_fragment (final_fragment),
        .close_code     (close_code)
    );

endmodule

// ===== design/wfr_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfr_checker
// port-level checks on the frame receiver, bound to the top level
// ---------------------------------------------------------------------------
`include "websocket_frame_receiver_assert.svh"

module wfr_checker import wfr_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  out_byte,
    input logic        last,
    input logic [15:0] close_code
);

    // a stalled result holds
    `WFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(out_byte) && $stable(close_code))

    // a close code only travels with a close result
    `WFR_ASSERT_SAME(a_code_only_close, out_valid && (kind != KIND_CLOSE), close_code == 16'd0)

    // non-payload results carry no byte and no last flag
    `WFR_ASSERT_SAME(a_no_byte, out_valid && (kind != KIND_DATA) && (kind != KIND_PING_BYTE), (out_byte == 8'h00) && !last)

    // nothing follows a close
    `WFR_ASSERT_NEXT(a_close_final, out_valid && out_ready && (kind == KIND_CLOSE), !out_valid)

endmodule

bind websocket_frame_receiver wfr_checker u_wfr_checker (.*);

// ===== verif/tb_websocket_frame_receiver.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_websocket_frame_receiver
// self-checking testbench for the byte-serial websocket frame receiver
// ---------------------------------------------------------------------------
// A frame tracker follows the receiver's header parser byte by byte and
// queues the result each accepted transfer should produce; every result
// transfer is checked field by field against the oldest queued one. The
// stimulus is a few directed frames, then well-formed frames with random
// content under several register settings, with read-timeout ticks mixed
// in. Any close leaves the receiver dead until reset, so each run ends with
// one protocol fault or peer close picked at random, followed by traffic
// that must be ignored.
module tb_websocket_frame_receiver import wfr_pkg::*;;

    // parser position inside a frame
    typedef enum logic [3:0] {
        ST_FIRST,
        ST_SECOND,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_KEY,
        ST_BODY,
        ST_DEAD
    } rx_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic        fin;
        logic [15:0] code;
    } frame_result_t;

    // tracks the frame being parsed and holds the results still due
    class frame_tracker;
        logic          mask_req;
        logic [1:0]    data_op;
        logic [15:0]   max_len;
        rx_state_t     st;
        logic [3:0]    op;
        logic          fin;
        logic          masked;
        logic [15:0]   plen;
        logic [15:0]   count;
        logic [31:0]   key;
        logic [15:0]   peer;
        frame_result_t due_results[$];
        int            errors;

        function new();
            mask_req  = 1'b1;
            data_op   = 2'd1;
            max_len   = 16'hFFFF;
            st        = ST_FIRST;
            op        = OP_CONT;
            fin       = 1'b0;
            masked    = 1'b0;
            plen      = '0;
            count     = '0;
            key       = '0;
            peer      = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_MASK_REQ:    mask_req = val[0];
                REG_DATA_TYPE:   data_op = val[1:0];
                REG_MAX_PAYLOAD: max_len = val;
                default: ;
            endcase
        endfunction

        function void owe(logic [2:0] k, logic [7:0] d, logic l, logic f, logic [15:0] c);
            frame_result_t r;
            r.kind = k;
            r.data = d;
            r.last = l;
            r.fin  = f;
            r.code = c;
            due_results.push_back(r);
        endfunction

        function void close_with(logic [15:0] c);
            st = ST_DEAD;
            owe(KIND_CLOSE, 8'h00, 1'b0, 1'b0, c);
        endfunction

        // end of header: opcode checks, then empty frames finish here
        function void finish_header();
            count = '0;
            peer  = '0;
            if (op == OP_TEXT || op == OP_BINARY)
            begin
                if (op != {2'b00, data_op})
                begin
                    close_with(CC_TYPE);
                    return;
                end
            end
            else if (op != OP_CONT && op != OP_CLOSE && op != OP_PING && op != OP_PONG)
            begin
                close_with(CC_PROTOCOL);
                return;
            end
            if (plen == 16'd0)
            begin
                st = ST_FIRST;
                if (op == OP_CLOSE)
                    close_with(CC_NORMAL);
                else if (op == OP_PING)
                    owe(KIND_PING_NULL, 8'h00, 1'b0, fin, 16'h0000);
            end
            else
            begin
                st = ST_BODY;
            end
        endfunction

        // length known: control frame rules and size limit
        function void check_length();
            if (op >= OP_CLOSE && (!fin || plen > CONTROL_MAX))
                close_with(CC_PROTOCOL);
            else if (plen > max_len)
                close_with(CC_OVERLARGE);
            else if (masked)
            begin
                count = '0;
                key   = '0;
                st    = ST_KEY;
            end
            else
                finish_header();
        endfunction

        // one payload byte: unmask and route by opcode
        function void body_byte(logic [7:0] b);
            logic [7:0]  ub;
            logic        is_last;
            logic [1:0]  lane;
            logic [15:0] idx;
            idx     = count;
            lane    = count[1:0];
            is_last = ({1'b0, count} + 17'd1) >= {1'b0, plen};
            ub      = masked ? (b ^ key[8 * (3 - lane) +: 8]) : b;
            count   = count + 16'd1;
            if (is_last)
                st = ST_FIRST;
            if (op == OP_CONT || op == OP_TEXT || op == OP_BINARY)
                owe(KIND_DATA, ub, is_last, fin, 16'h0000);
            else if (op == OP_PING)
                owe(KIND_PING_BYTE, ub, is_last, fin, 16'h0000);
            else if (op == OP_CLOSE)
            begin
                if (idx < 16'd2)
                    peer = {peer[7:0], ub};
                if (is_last)
                    close_with(plen >= 16'd2 ? peer : CC_NORMAL);
            end
        endfunction

        // accepted input transfer
        function void take_item(logic c, logic [7:0] b);
            logic [6:0] len7;
            if (st == ST_DEAD)
                return;
            if (c)
            begin
                if (st == ST_FIRST)
                    owe(KIND_KEEPALIVE, 8'h00, 1'b0, 1'b0, 16'h0000);
                return;
            end
            case (st)
                ST_FIRST:
                begin
                    fin = b[7];
                    op  = b[3:0];
                    st  = ST_SECOND;
                end
                ST_SECOND:
                begin
                    masked = b[7];
                    len7   = b[6:0];
                    if (masked != mask_req)
                        close_with(CC_PROTOCOL);
                    else if (len7 == LEN7_EXT64)
                        close_with(CC_OVERLARGE);
                    else if (len7 == LEN7_EXT16)
                    begin
                        plen = '0;
                        st   = ST_LEN_HI;
                    end
                    else
                    begin
                        plen = {9'd0, len7};
                        check_length();
                    end
                end
                ST_LEN_HI:
                begin
                    plen = {b, 8'h00};
                    st   = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    plen = plen | {8'h00, b};
                    if (plen < {9'd0, LEN7_EXT16})
                        close_with(CC_PROTOCOL);
                    else
                        check_length();
                end
                ST_KEY:
                begin
                    key   = {key[23:0], b};
                    count = count + 16'd1;
                    if (count >= 16'd4)
                        finish_header();
                end
                ST_BODY: body_byte(b);
                default: st = ST_DEAD;
            endcase
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        // accepted result transfer
        function void check_result(logic [2:0] k, logic [7:0] d, logic l, logic f,
                                   logic [15:0] c);
            frame_result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with none due, expected nothing, actual kind %0d",
                         $time, k);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("kind", {13'd0, want.kind}, {13'd0, k});
            compare_field("out_byte", {8'd0, want.data}, {8'd0, d});
            compare_field("last", {15'd0, want.last}, {15'd0, l});
            compare_field("final_fragment", {15'd0, want.fin}, {15'd0, f});
            compare_field("close_code", want.code, c);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic        last;
    logic        final_fragment;
    logic [15:0] close_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    frame_tracker tracker;
    int           sent_count;
    bit           tx_gaps;
    bit           rx_gaps;
    bit           tick_noise;
    int           hold_cycles;
    logic         cur_mask_req;
    logic [1:0]   cur_data_op;
    logic [15:0]  cur_max;

    websocket_frame_receiver i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .out_byte       (out_byte),
        .last           (last),
        .final_fragment (final_fragment),
        .close_code     (close_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("FAIL websocket_frame_receiver");
        $finish;
    end

    // result side: check at the rising edge, set ready at the falling edge
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.check_result(kind, out_byte, last, final_fragment, close_code);
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= !(rx_gaps && $urandom_range(0, 99) < 9);
        end
    end

    // one input transfer, entered and left at a falling edge
    task automatic send_item(input logic c, input logic [7:0] b);
        if (tx_gaps && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_item(c, b);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_bytes(input logic [7:0] bytes_q[$]);
        foreach (bytes_q[i])
        begin
            if (tick_noise && $urandom_range(0, 99) < 2)
                send_item(1'b1, 8'($urandom));
            send_item(1'b0, bytes_q[i]);
        end
    endtask

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // well-formed header, key and random payload
    task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input logic [15:0] len);
        logic [7:0] q[$];
        q.push_back({fin, 3'($urandom_range(0, 7)), op});
        if (len < 16'd126)
            q.push_back({masked, len[6:0]});
        else
        begin
            q.push_back({masked, LEN7_EXT16});
            q.push_back(len[15:8]);
            q.push_back(len[7:0]);
        end
        if (masked)
            repeat (4) q.push_back(rand_byte());
        repeat (len) q.push_back(rand_byte());
        send_bytes(q);
    endtask

    // mostly short payloads, a few extended lengths, sometimes the limit itself
    function automatic logic [15:0] pick_len(bit ctrl);
        logic [15:0] lim;
        int          r;
        lim = ctrl ? CONTROL_MAX : 16'd200;
        if (cur_max < lim)
            lim = cur_max;
        r = $urandom_range(0, 99);
        if (lim == 16'd0)
            return 16'd0;
        if (r < 5)
            return lim;
        if (r < 15)
            return 16'd0;
        if (r < 75)
            return 16'($urandom_range(1, lim < 16'd12 ? lim : 16'd12));
        if (r < 90)
            return 16'($urandom_range(1, lim < 16'd125 ? lim : 16'd125));
        return 16'($urandom_range(1, lim));
    endfunction

    task automatic random_frame();
        logic [3:0] op;
        logic       ctrl;
        int         r;
        if (tick_noise && $urandom_range(0, 99) < 6)
            send_item(1'b1, 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 35)
            op = {2'b00, cur_data_op};
        else if (r < 50)
            op = OP_CONT;
        else if (r < 75)
            op = OP_PING;
        else
            op = OP_PONG;
        ctrl = (op >= OP_CLOSE);
        send_frame(ctrl ? 1'b1 : 1'($urandom_range(0, 1)), op, cur_mask_req, pick_len(ctrl));
    endtask

    task automatic run_frames(input int upto);
        while (sent_count < upto)
            random_frame();
    endtask

    // stop offering and wait until every due result has been seen
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_config(input logic nm, input logic [1:0] dop, input logic [15:0] mx);
        drain();
        write_reg(REG_MASK_REQ, {15'd0, nm});
        write_reg(REG_DATA_TYPE, {14'd0, dop});
        write_reg(REG_MAX_PAYLOAD, mx);
        cfg_valid    <= 1'b0;
        cur_mask_req = nm;
        cur_data_op  = dop;
        cur_max      = mx;
    endtask

    // one fault or peer close to finish the run, then traffic that is ignored
    task automatic end_with_close();
        logic [7:0]  q[$];
        logic [7:0]  hdr;
        logic [3:0]  op;
        logic [15:0] mx;
        logic        m;
        int          sel;
        m   = cur_mask_req;
        hdr = {4'b1000, 2'b00, cur_data_op};
        sel = $urandom_range(0, 11);
        case (sel)
            0:
            begin
                q = '{hdr, {~m, 7'd5}};
                send_bytes(q);
            end
            1:
            begin
                q = '{hdr, {m, LEN7_EXT64}};
                send_bytes(q);
            end
            2:
            begin
                // extended length that would have fitted in seven bits
                q = '{hdr, {m, LEN7_EXT16}, 8'h00, 8'($urandom_range(0, 125))};
                send_bytes(q);
            end
            3: send_frame(1'b0, OP_PING, m, 16'd0);
            4:
            begin
                q = '{{4'b1000, OP_PING}, {m, LEN7_EXT16}, 8'h00, 8'd126};
                send_bytes(q);
            end
            5:
            begin
                if ($urandom_range(0, 1))
                begin
                    set_config(m, cur_data_op, 16'hFFFE);
                    q = '{hdr, {m, LEN7_EXT16}, 8'hFF, 8'hFF};
                    send_bytes(q);
                end
                else
                begin
                    mx = 16'($urandom_range(0, 100));
                    set_config(m, cur_data_op, mx);
                    send_frame(1'b1, {2'b00, cur_data_op}, m, mx + 16'd1);
                end
            end
            6:
            begin
                set_config(m, 2'd2, cur_max);
                send_frame(1'b1, OP_TEXT, m, 16'd3);
            end
            7:
            begin
                do
                    op = 4'($urandom_range(3, 15));
                while (op == OP_CLOSE || op == OP_PING || op == OP_PONG);
                send_frame(1'b1, op, m, 16'($urandom_range(0, 3)));
            end
            8: send_frame(1'b1, OP_CLOSE, m, 16'($urandom_range(2, 10)));
            9: send_frame(1'b1, OP_CLOSE, m, 16'd1);
            10: send_frame(1'b1, OP_CLOSE, m, 16'd0);
            default:
            begin
                // data opcode register matching neither text nor binary
                set_config(m, $urandom_range(0, 1) ? 2'd0 : 2'd3, cur_max);
                send_frame(1'b1, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY, m, 16'd2);
            end
        endcase
        repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    // stimulus
    initial
    begin
        logic [7:0] q[$];
        tracker      = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = 1'b0;
        in_byte      = 8'h00;
        cfg_valid    = 1'b0;
        cfg_index    = REG_MASK_REQ;
        cfg_data     = 16'h0000;
        tx_gaps      = 1'b1;
        rx_gaps      = 1'b1;
        tick_noise   = 1'b0;
        hold_cycles  = 0;
        sent_count   = 0;
        cur_mask_req = 1'b1;
        cur_data_op  = 2'd1;
        cur_max      = 16'hFFFF;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: keepalive, empty ping and pong, all-ones key with a tick inside
        send_item(1'b1, 8'h00);
        send_frame(1'b1, OP_PING, 1'b1, 16'd0);
        send_frame(1'b1, OP_PONG, 1'b1, 16'd0);
        q = '{8'hF1, 8'h82, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_bytes(q);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);

        // server, text, no size limit; long output stall part way through
        tick_noise = 1'b1;
        set_config(1'b1, 2'd1, 16'hFFFF);
        run_frames(sent_count + 120);
        hold_cycles = 300;
        run_frames(sent_count + 230);

        // client side, binary
        set_config(1'b0, 2'd2, 16'hFFFF);
        run_frames(sent_count + 300);

        // no idling on either side
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        set_config(1'b1, 2'd2, 16'($urandom_range(200, 1000)));
        run_frames(sent_count + 350);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // zero size limit: only empty frames get through
        set_config(1'b0, 2'd1, 16'd0);
        run_frames(sent_count + 100);

        // limit at the smallest extended length
        set_config(1'b1, 2'd1, 16'd126);
        run_frames(sent_count + 250);

        end_with_close();
        drain();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("PASS websocket_frame_receiver");
        else
            $display("FAIL websocket_frame_receiver");
        $finish;
    end

endmodule
